FILE: src/dti_pkg.sv
// ---------------------------------------------------------------------------
// dti_pkg: shared definitions for the decimal to int32 converter.
// Holds widths, the divide-by-ten constants and the control command word.
// ---------------------------------------------------------------------------
package dti_pkg;

  // Magnitude and scale widths.
  localparam int WORD_W  = 32;
  localparam int MANT_W  = 3 * WORD_W;
  localparam int SCALE_W = 5;

  // The magnitude is divided by ten one chunk at a time, top chunk first.
  localparam int CHUNK_W    = 16;
  localparam int NUM_CHUNKS = MANT_W / CHUNK_W;
  localparam int CHUNK_CNT_W = $clog2(NUM_CHUNKS);
  localparam int REM_W      = 4;
  localparam int CUR_W      = REM_W + CHUNK_W;

  // A chunk with its incoming remainder is below 10 * 2^16, so the
  // quotient by ten is (cur * DIV10_MAGIC) >> DIV10_SHIFT exactly.
  localparam int MAGIC_W     = 20;
  localparam int PROD_W      = CUR_W + MAGIC_W;
  localparam int DIV10_SHIFT = 23;
  localparam logic [MAGIC_W-1:0] DIV10_MAGIC = 20'd838861;

  // Largest magnitude that a negative result may have.
  localparam logic [WORD_W-1:0] INT_MIN_MAG = 32'h8000_0000;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new input word
    logic step;       // divide the top chunk by ten and rotate
    logic digit_end;  // this step finishes one divide by ten
    logic finish;     // range check and present the result
  } ctrl_cmd_t;

endpackage

FILE: src/dti_ctrl.sv
// ---------------------------------------------------------------------------
// dti_ctrl: sequencer for the decimal to int32 converter.
// Counts decimal digits and chunks, and issues datapath commands.
// ---------------------------------------------------------------------------
module dti_ctrl (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dti_pkg::SCALE_W-1:0] scale,
  output logic                        busy,
  output dti_pkg::ctrl_cmd_t          cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_DIVIDE = 3'b010,
    ST_CHECK  = 3'b100
  } state_t;

  localparam logic [dti_pkg::CHUNK_CNT_W-1:0] LAST_CHUNK =
    dti_pkg::CHUNK_CNT_W'(dti_pkg::NUM_CHUNKS - 1);

  state_t                          state, state_next;
  logic [dti_pkg::SCALE_W-1:0]     digit_cnt, digit_cnt_next;
  logic [dti_pkg::CHUNK_CNT_W-1:0] chunk_cnt, chunk_cnt_next;
  logic                            accept;
  logic                            last_chunk;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign last_chunk = (chunk_cnt == LAST_CHUNK);

  // Next state and counter updates.
  always_comb begin
    state_next     = state;
    digit_cnt_next = digit_cnt;
    chunk_cnt_next = chunk_cnt;
    cmd            = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load       = 1'b1;
          digit_cnt_next = scale;
          chunk_cnt_next = '0;
          state_next     = (scale == '0) ? ST_CHECK : ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        cmd.step = 1'b1;
        if (last_chunk) begin
          cmd.digit_end  = 1'b1;
          chunk_cnt_next = '0;
          digit_cnt_next = digit_cnt - dti_pkg::SCALE_W'(1);
          if (digit_cnt == dti_pkg::SCALE_W'(1)) begin
            state_next = ST_CHECK;
          end
        end else begin
          chunk_cnt_next = chunk_cnt + dti_pkg::CHUNK_CNT_W'(1);
        end
      end
      ST_CHECK: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      digit_cnt <= '0;
      chunk_cnt <= '0;
    end else begin
      state     <= state_next;
      digit_cnt <= digit_cnt_next;
      chunk_cnt <= chunk_cnt_next;
    end
  end

`ifndef SYNTHESIS
  // An accepted word always makes the block busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("block not busy after accepting a word");

  // The range check is always followed directly by idle.
  a_check_once: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHECK) |=> (state == ST_IDLE))
    else $error("range check did not return to idle");

  // A digit ends only on the last chunk, and the digit count is never
  // exhausted while dividing.
  a_digit_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (digit_cnt != '0))
    else $error("dividing with no digits left");
`endif

endmodule

FILE: src/dti_datapath.sv
// ---------------------------------------------------------------------------
// dti_datapath: magnitude register, divide-by-ten step and range check.
// One 16-bit chunk is divided per step; six steps make one divide by ten.
// ---------------------------------------------------------------------------
module dti_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  dti_pkg::ctrl_cmd_t                cmd,
  input  logic [dti_pkg::WORD_W-1:0]        mant_low,
  input  logic [dti_pkg::WORD_W-1:0]        mant_mid,
  input  logic [dti_pkg::WORD_W-1:0]        mant_high,
  input  logic                              negative,
  output logic                              done,
  output logic signed [dti_pkg::WORD_W-1:0] int_value,
  output logic                              overflow
);

  logic [dti_pkg::MANT_W-1:0]  mant;
  logic [dti_pkg::REM_W-1:0]   rem;
  logic                        neg;
  logic [dti_pkg::CUR_W-1:0]   cur;
  logic [dti_pkg::PROD_W-1:0]  prod;
  logic [dti_pkg::CHUNK_W-1:0] quot;
  logic [dti_pkg::CUR_W-1:0]   quot_x10;
  logic [dti_pkg::CUR_W-1:0]   diff;
  logic [dti_pkg::WORD_W-1:0]  low_word;
  logic                        ovf;

  // Divide the top chunk, with the remainder carried from above, by ten.
  assign cur      = {rem, mant[dti_pkg::MANT_W-1 -: dti_pkg::CHUNK_W]};
  assign prod     = dti_pkg::PROD_W'(cur) * dti_pkg::PROD_W'(dti_pkg::DIV10_MAGIC);
  assign quot     = prod[dti_pkg::DIV10_SHIFT +: dti_pkg::CHUNK_W];
  assign quot_x10 = {1'b0, quot, 3'b000} + {3'b000, quot, 1'b0};
  assign diff     = cur - quot_x10;

  // Range check of the truncated magnitude.
  assign low_word = mant[dti_pkg::WORD_W-1:0];
  assign ovf = (mant[dti_pkg::MANT_W-1:dti_pkg::WORD_W] != '0) ||
               (!neg && low_word[dti_pkg::WORD_W-1]) ||
               (neg && (low_word > dti_pkg::INT_MIN_MAG));

  // Magnitude register: the quotient chunk enters at the bottom, so after
  // six steps the word is back in its original order.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mant <= {mant_high, mant_mid, mant_low};
      rem  <= '0;
      neg  <= negative;
    end else if (cmd.step) begin
      mant <= {mant[dti_pkg::MANT_W-dti_pkg::CHUNK_W-1:0], quot};
      rem  <= cmd.digit_end ? '0 : diff[dti_pkg::REM_W-1:0];
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      overflow  <= ovf;
      if (ovf) begin
        int_value <= '0;
      end else if (neg) begin
        int_value <= -$signed(low_word);
      end else begin
        int_value <= $signed(low_word);
      end
    end
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

`ifndef SYNTHESIS
  // The carried remainder is always a decimal digit.
  a_rem_digit: assert property (@(posedge clk) disable iff (rst)
    (cmd.step || cmd.finish) |-> (rem <= dti_pkg::REM_W'(9)))
    else $error("remainder out of digit range");

  // An overflowing result always reads as zero.
  a_ovf_zero: assert property (@(posedge clk) disable iff (rst)
    (done && overflow) |-> (int_value == '0))
    else $error("overflow result is not zero");
`endif

endmodule

FILE: src/decimal96_to_int32.sv
// An accepted start loads the word; the divides by ten follow, then the range
// check, whose result is registered. Busy is low in the done cycle.
// Each divide by ten walks the 96-bit magnitude as six 16-bit chunks through
// one shared multiply-by-reciprocal unit, one chunk per cycle.
// Reset is synchronous and clears the sequencer and the done strobe.
// The done strobe is high for one cycle and cannot be held off.
// ---------------------------------------------------------------------------
// decimal96_to_int32: scaled decimal to signed 32-bit integer converter.
// Truncates a 96-bit magnitude by its decimal scale and range checks it.
// ---------------------------------------------------------------------------
module decimal96_to_int32 (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [dti_pkg::WORD_W-1:0]        mant_low,
  input  logic [dti_pkg::WORD_W-1:0]        mant_mid,
  input  logic [dti_pkg::WORD_W-1:0]        mant_high,
  input  logic [dti_pkg::SCALE_W-1:0]       scale,
  input  logic                              negative,
  output logic                              done,
  output logic signed [dti_pkg::WORD_W-1:0] int_value,
  output logic                              overflow
);

  dti_pkg::ctrl_cmd_t cmd;

  // Sequencer.
  dti_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .scale (scale),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Datapath.
  dti_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .mant_low  (mant_low),
    .mant_mid  (mant_mid),
    .mant_high (mant_high),
    .negative  (negative),
    .done      (done),
    .int_value (int_value),
    .overflow  (overflow)
  );

endmodule
